@@ rtl/sequential_list_keyed_removal_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the keyed list
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SEQUENTIAL_LIST_KEYED_REMOVAL_ASSERT_SVH
`define SEQUENTIAL_LIST_KEYED_REMOVAL_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define SLKR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define SLKR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/slkr_pkg.sv @@
// ----------------------------------------------------------------------------
// slkr_pkg
// Types and codes shared by the keyed list modules.
// ----------------------------------------------------------------------------
package slkr_pkg;

  localparam int KeyW      = 64;
  localparam int DeadlineW = 16;
  localparam int CountOutW = 7;

  typedef enum logic {
    REQ_APPEND = 1'b0,
    REQ_REMOVE = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_APPENDED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_REMOVED   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic                 req_type;
    logic [KeyW-1:0]      key;
    logic [DeadlineW-1:0] deadline;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [CountOutW-1:0] count;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_RESP
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic    load_req;
    logic    idx_clr;
    logic    idx_inc;
    logic    rd_en;
    logic    rd_next;   // read idx+1 instead of idx
    logic    wr_tail;   // append write at count
    logic    wr_shift;  // move read entry down to idx
    logic    cnt_inc;
    logic    cnt_dec;
    logic    st_set;
    status_e st_val;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_remove;
    logic full;
    logic empty;
    logic key_hit;
    logic next_in_list;  // idx+1 < count
  } ctrl_sts_t;

endpackage

@@ rtl/slkr_ram.sv @@
// ----------------------------------------------------------------------------
// slkr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slkr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/slkr_ctrl.sv @@
// ----------------------------------------------------------------------------
// slkr_ctrl
// Request sequencer: append, head-first scan, shift-down and response.
// ----------------------------------------------------------------------------
module slkr_ctrl
  import slkr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd_o.idx_clr = 1'b1;
        cmd_o.st_set  = 1'b1;
        if (!sts_i.is_remove) begin
          if (sts_i.full) begin
            cmd_o.st_val = ST_FULL;
          end else begin
            cmd_o.st_val  = ST_APPENDED;
            cmd_o.wr_tail = 1'b1;
            cmd_o.cnt_inc = 1'b1;
          end
          state_d = S_RESP;
        end else if (sts_i.empty) begin
          cmd_o.st_val = ST_NOT_FOUND;
          state_d      = S_RESP;
        end else begin
          cmd_o.st_set = 1'b0;
          state_d      = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (sts_i.key_hit) begin
          state_d = S_SHIFT_RD;
        end else if (sts_i.next_in_list) begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_SCAN_RD;
        end else begin
          cmd_o.st_set = 1'b1;
          cmd_o.st_val = ST_NOT_FOUND;
          state_d      = S_RESP;
        end
      end
      S_SHIFT_RD: begin
        if (sts_i.next_in_list) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_next = 1'b1;
          state_d       = S_SHIFT_WR;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          cmd_o.st_set  = 1'b1;
          cmd_o.st_val  = ST_REMOVED;
          state_d       = S_RESP;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.idx_inc  = 1'b1;
        state_d        = S_SHIFT_RD;
      end
      S_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/slkr_datapath.sv @@
// ----------------------------------------------------------------------------
// slkr_datapath
// Request register, entry count, scan index, entry stores and result register.
// ----------------------------------------------------------------------------
module slkr_datapath
  import slkr_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  req_t      req_i,
  input  ctrl_cmd_t cmd_i,
  output ctrl_sts_t sts_o,
  output rsp_t      rsp_o
);

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  req_t                 req_q;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [CntW-1:0]      idx_q, idx_d;
  logic [CntW-1:0]      idx_nxt;
  status_e              status_q;

  logic                 we;
  logic [IdxW-1:0]      waddr, raddr;
  logic [KeyW-1:0]      key_wdata, key_rdata;
  logic [DeadlineW-1:0] dl_wdata, dl_rdata;

  assign idx_nxt = idx_q + CntW'(1);

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CntW'(1);
    end
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= req_i;
    end
    if (cmd_i.st_set) begin
      status_q <= cmd_i.st_val;
    end
  end

  // tail write for append, shift-down write during removal
  assign we        = cmd_i.wr_tail | cmd_i.wr_shift;
  assign waddr     = cmd_i.wr_tail ? cnt_q[IdxW-1:0] : idx_q[IdxW-1:0];
  assign key_wdata = cmd_i.wr_tail ? req_q.key : key_rdata;
  assign dl_wdata  = cmd_i.wr_tail ? req_q.deadline : dl_rdata;
  assign raddr     = cmd_i.rd_next ? idx_nxt[IdxW-1:0] : idx_q[IdxW-1:0];

  slkr_ram #(
    .WIDTH(KeyW),
    .DEPTH(CAPACITY)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(key_wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(raddr),
    .rdata_o(key_rdata)
  );

  slkr_ram #(
    .WIDTH(DeadlineW),
    .DEPTH(CAPACITY)
  ) u_deadline_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(dl_wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(raddr),
    .rdata_o(dl_rdata)
  );

  assign sts_o.is_remove    = (req_q.req_type == REQ_REMOVE);
  assign sts_o.full         = (cnt_q == CntW'(CAPACITY));
  assign sts_o.empty        = (cnt_q == '0);
  assign sts_o.key_hit      = (key_rdata == req_q.key);
  assign sts_o.next_in_list = (idx_nxt < cnt_q);

  assign rsp_o.status = status_q;
  assign rsp_o.count  = CountOutW'(cnt_q);

endmodule

@@ rtl/sequential_list_keyed_removal.sv @@
// ----------------------------------------------------------------------------
// sequential_list_keyed_removal
// Bounded list of key/deadline entries with tail append and remove-by-key.
// ----------------------------------------------------------------------------
//
//  channel | handshake             | payload    | one item carries
//  --------+-----------------------+------------+------------------------------
//  in      | in_valid_i/in_ready_o | in_data_i  | req_type, key, deadline
//  out     | out_valid_o/out_ready_i| out_data_o| status, count after request
//
//  One item in, one item out; the next item is taken once the result is gone,
//  in the idle state that follows.
//  Append: from acceptance the request passes dispatch, then response.
//  Remove: dispatch, then a read and a compare per entry from the head up to
//  the match, then a read and a shift-down write per later entry, then response;
//  a miss scans the whole list. The single read port of the entry stores sets this.
//  Reset clears the entry count and scan index; the stores need no clearing pass.
//  A stalled result holds in the response state until out_ready_i is high.
// ----------------------------------------------------------------------------
module sequential_list_keyed_removal
  import slkr_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  // controller <-> datapath
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencer: accepts in idle, walks scan/shift, holds result in response
  slkr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // entry stores, count, index and result register
  slkr_datapath #(
    .CAPACITY(CAPACITY)
  ) u_datapath (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (in_data_i),
    .cmd_i (cmd),
    .sts_o (sts),
    .rsp_o (out_data_o)
  );

endmodule

@@ rtl/slkr_checker.sv @@
// ----------------------------------------------------------------------------
// slkr_checker
// Port-level checks for the keyed list, bound to the top level.
// ----------------------------------------------------------------------------
`include "sequential_list_keyed_removal_assert.svh"

module slkr_checker
  import slkr_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input req_t in_data_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input rsp_t out_data_o
);

  `SLKR_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result changed while stalled")
  `SLKR_ASSERT_SAME(a_one_at_a_time, out_valid_o, !in_ready_o, "ready for a new item while a result waits")
  `SLKR_ASSERT_NEXT(a_no_instant_rsp, in_valid_i && in_ready_o, !out_valid_o && !in_ready_o, "result in the cycle after acceptance")
  `SLKR_ASSERT_SAME(a_count_bound, out_valid_o, (CAPACITY > 127) || (int'(out_data_o.count) <= CAPACITY), "count above capacity")
  `SLKR_ASSERT_SAME(a_full_count, out_valid_o && (out_data_o.status == ST_FULL), out_data_o.count == CountOutW'(CAPACITY), "full reported below capacity")

endmodule

bind sequential_list_keyed_removal slkr_checker #(.CAPACITY(CAPACITY)) u_slkr_checker (.*);

@@ tb/tb_sequential_list_keyed_removal.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sequential_list_keyed_removal
// Self-checking bench for the keyed list. Requests go in from a queue that is
// filled up front. A model of the list, kept in the bench, is updated on each
// accepted request and queues the status and count it expects. The monitor
// compares each result item against the oldest expectation. Both handshakes
// see random gaps and stalls, with calm stretches between them.
// ----------------------------------------------------------------------------
module tb_sequential_list_keyed_removal;
  import slkr_pkg::*;

  localparam int CAPACITY    = 64;
  localparam int ClkHalf     = 6;
  localparam int NumRandom   = 1600;
  localparam int PoolSize    = 16;
  // margin for the tail beyond the slowest remove
  localparam int DrainCycles = 3 * CAPACITY + 20;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_data  = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp_data;

  int error_count = 0;

  sequential_list_keyed_removal #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (req_valid),
    .in_ready_o (req_ready),
    .in_data_i  (req_data),
    .out_valid_o(rsp_valid),
    .out_ready_i(rsp_ready),
    .out_data_o (rsp_data)
  );

  always begin
    #(ClkHalf) clk = 1'b1;
    #(ClkHalf) clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // List model: mirrors the entries held by the block, updated in request order
  // --------------------------------------------------------------------------
  logic [KeyW-1:0]      list_keys      [CAPACITY];
  logic [DeadlineW-1:0] list_deadlines [CAPACITY];
  int                   list_len = 0;
  rsp_t                 expected_rsps [$];

  function automatic void apply_request(input req_t r);
    rsp_t exp_rsp;
    int   hit = -1;
    if (r.req_type == REQ_APPEND) begin
      if (list_len >= CAPACITY) begin
        // full: nothing stored, count unchanged
        exp_rsp.status = ST_FULL;
      end else begin
        list_keys[list_len]      = r.key;
        list_deadlines[list_len] = r.deadline;
        list_len++;
        exp_rsp.status = ST_APPENDED;
      end
    end else begin
      // first match from the head wins; duplicates further back stay put
      for (int i = 0; i < list_len; i++) begin
        if (hit < 0 && list_keys[i] == r.key) hit = i;
      end
      if (hit < 0) begin
        exp_rsp.status = ST_NOT_FOUND;
      end else begin
        // close the gap toward the head
        for (int i = hit; i + 1 < list_len; i++) begin
          list_keys[i]      = list_keys[i + 1];
          list_deadlines[i] = list_deadlines[i + 1];
        end
        list_len--;
        exp_rsp.status = ST_REMOVED;
      end
    end
    exp_rsp.count = list_len[CountOutW-1:0];
    expected_rsps.push_back(exp_rsp);
  endfunction

  // Random per-item wait, with occasional calm runs of back-to-back items.
  function automatic int unsigned draw_wait(inout int unsigned calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic logic [KeyW-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: pops pending items, holds each until taken
  // --------------------------------------------------------------------------
  req_t        pending_reqs [$];
  int unsigned req_gap  = 0;
  int unsigned req_calm = 0;

  always @(posedge clk) begin
    if (rst_n && (!req_valid || req_ready)) begin
      // item taken at this edge: advance the model
      if (req_valid) apply_request(req_data);
      if (req_gap > 0) begin
        req_valid <= 1'b0;
        req_gap   <= req_gap - 1;
      end else if (pending_reqs.size() != 0) begin
        req_data  <= pending_reqs.pop_front();
        req_valid <= 1'b1;
        req_gap   <= draw_wait(req_calm);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: checks each accepted item, then stalls a random while
  // --------------------------------------------------------------------------
  int unsigned rsp_stall = 0;
  int unsigned rsp_calm  = 0;

  always @(posedge clk) begin
    rsp_t        exp_rsp;
    int unsigned w;
    if (rst_n) begin
      w = rsp_stall;
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, actual status=%0d count=%0d",
                   $time, rsp_data.status, rsp_data.count);
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (rsp_data.status !== exp_rsp.status || rsp_data.count !== exp_rsp.count) begin
            error_count++;
            $display("%0t: mismatch, expected status=%0d count=%0d, actual status=%0d count=%0d",
                     $time, exp_rsp.status, exp_rsp.count, rsp_data.status, rsp_data.count);
          end
        end
        w = draw_wait(rsp_calm);
      end
      if (w > 0) begin
        rsp_ready <= 1'b0;
        rsp_stall <= w - 1;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  task automatic add_req(input req_e kind, input logic [KeyW-1:0] k,
                         input logic [DeadlineW-1:0] d);
    req_t r;
    r.req_type = kind;
    r.key      = k;
    r.deadline = d;
    pending_reqs.push_back(r);
  endtask

  initial begin
    logic [KeyW-1:0] key_pool [PoolSize];
    logic [KeyW-1:0] k;
    logic [KeyW-1:0] name_a;
    logic [KeyW-1:0] name_b;
    int              n;
    int              phase_left;
    logic            filling;

    name_a = 64'h4142_4344_0000_0000;  // "ABCD", zero padded
    name_b = 64'h5845_5900_0000_0000;  // "XEY"

    // remove from an empty list: not found, count 0
    add_req(REQ_REMOVE, '0, '0);
    // extremes of key and deadline, alternating bit patterns
    add_req(REQ_APPEND, '0, '0);
    add_req(REQ_APPEND, '1, '1);
    add_req(REQ_APPEND, 64'hAAAA_AAAA_AAAA_AAAA, 16'h5555);
    add_req(REQ_APPEND, 64'h5555_5555_5555_5555, 16'hAAAA);
    // duplicate key: only the one nearest the head goes
    add_req(REQ_APPEND, name_a, 16'd1234);
    add_req(REQ_APPEND, name_b, 16'd60);
    add_req(REQ_APPEND, name_a, 16'd5678);
    add_req(REQ_REMOVE, name_a, '1);  // deadline ignored on remove
    add_req(REQ_REMOVE, name_a, '0);
    add_req(REQ_REMOVE, name_a, '0);  // both gone now
    // miss on a populated list, then head, middle and tail removes
    add_req(REQ_REMOVE, 64'h0000_0000_0000_0001, '0);
    add_req(REQ_REMOVE, '0, '0);
    add_req(REQ_REMOVE, 64'h5555_5555_5555_5555, '0);
    add_req(REQ_REMOVE, name_b, '0);
    add_req(REQ_REMOVE, '1, '0);
    add_req(REQ_REMOVE, 64'hAAAA_AAAA_AAAA_AAAA, '0);
    // back to empty
    add_req(REQ_REMOVE, '1, '1);

    // Random part: alternating fill and drain phases over a small key pool so
    // removes mostly hit and the list runs up to full and back down.
    for (int i = 0; i < PoolSize; i++) key_pool[i] = rand_key();
    n          = 0;
    phase_left = 0;
    filling    = 1'b0;
    while (n < NumRandom) begin
      if (phase_left == 0) begin
        filling    = !filling;
        phase_left = $urandom_range(60, 140);
      end
      phase_left--;
      if ($urandom_range(0, 99) == 0) key_pool[$urandom_range(0, PoolSize - 1)] = rand_key();
      if ($urandom_range(0, 99) < (filling ? 85 : 20)) begin
        k = ($urandom_range(0, 99) < 3) ? rand_key() : key_pool[$urandom_range(0, PoolSize - 1)];
        add_req(REQ_APPEND, k, DeadlineW'($urandom));
      end else begin
        // some removes carry a fresh key and should miss
        k = ($urandom_range(0, 99) < 10) ? rand_key() : key_pool[$urandom_range(0, PoolSize - 1)];
        add_req(REQ_REMOVE, k, DeadlineW'($urandom));
      end
      n++;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || req_valid) @(negedge clk);
    while (expected_rsps.size() != 0) @(negedge clk);
    // let any stray result show up before calling it
    repeat (DrainCycles) @(negedge clk);

    if (expected_rsps.size() != 0) begin
      error_count++;
      $display("%0t: %0d results never arrived, expected status=%0d count=%0d",
               $time, expected_rsps.size(), expected_rsps[0].status, expected_rsps[0].count);
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Timeout guard, well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ sequential_list_keyed_removal.f @@
+incdir+rtl
rtl/slkr_pkg.sv
rtl/slkr_ram.sv
rtl/slkr_ctrl.sv
rtl/slkr_datapath.sv
rtl/sequential_list_keyed_removal.sv
rtl/slkr_checker.sv
tb/tb_sequential_list_keyed_removal.sv
